// ----- rtl/y420rgb_pkg.sv -----
// Shared types and constants for the YUV 4:2:0 block to RGB converter.
// No dependencies; every other file in rtl/ refers to this package.
`default_nettype none

package y420rgb_pkg;

  // Number of pixels in one 2x2 block, one lane each.
  localparam int unsigned LANES = 4;

  // Sample and packed-pixel widths.
  localparam int unsigned SAMPLE_W = 8;
  localparam int unsigned PIXEL_W  = 3 * SAMPLE_W;

  // Signed width of the fixed-point sums. The largest magnitude is the blue sum,
  // which stays inside +/-2^18.
  localparam int unsigned SUM_W = 20;

  // BT.601 integer coefficients and offsets.
  localparam logic signed [SUM_W-1:0] COEF_Y    = SUM_W'(298);
  localparam logic signed [SUM_W-1:0] COEF_R_CR = SUM_W'(409);
  localparam logic signed [SUM_W-1:0] COEF_G_CB = SUM_W'(100);
  localparam logic signed [SUM_W-1:0] COEF_G_CR = SUM_W'(208);
  localparam logic signed [SUM_W-1:0] COEF_B_CB = SUM_W'(516);
  localparam logic signed [SUM_W-1:0] ROUND     = SUM_W'(128);
  localparam logic signed [SUM_W-1:0] LUMA_OFS  = SUM_W'(16);
  localparam logic signed [SUM_W-1:0] CHROMA_OFS = SUM_W'(128);

  // Configuration port geometry and register indexes.
  localparam int unsigned PADDR_W   = 4;
  localparam int unsigned PDATA_W   = 32;
  localparam int unsigned REG_IDX_W = 2;

  localparam logic [REG_IDX_W-1:0] REG_SHOW_LUMA      = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_SHOW_BLUE_DIFF = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_SHOW_RED_DIFF  = 2'd2;

  // Per-item chroma contribution, shared by all four lanes.
  typedef struct packed {
    logic signed [SUM_W-1:0] r_term;
    logic signed [SUM_W-1:0] g_term;
    logic signed [SUM_W-1:0] b_term;
    logic                    gray_en;
    logic                    gray_luma;
    logic [SAMPLE_W-1:0]     gray_val;
  } chroma_terms_t;

  // One converted pixel.
  typedef struct packed {
    logic [SAMPLE_W-1:0] r;
    logic [SAMPLE_W-1:0] g;
    logic [SAMPLE_W-1:0] b;
  } pixel_t;

endpackage

`default_nettype wire

// ----- rtl/y420rgb_chroma.sv -----
// Shared chroma stage: masks Cb/Cr and registers their terms for all lanes.
// Depends on y420rgb_pkg.
`default_nettype none

module y420rgb_chroma (
  input  wire logic                                 clk_i,
  input  wire logic                                 show_luma_i,
  input  wire logic                                 show_blue_diff_i,
  input  wire logic                                 show_red_diff_i,
  input  wire logic [y420rgb_pkg::SAMPLE_W-1:0]     chroma_blue_i,
  input  wire logic [y420rgb_pkg::SAMPLE_W-1:0]     chroma_red_i,
  output y420rgb_pkg::chroma_terms_t                terms_o
);

  logic [y420rgb_pkg::SAMPLE_W-1:0]        cb_m;
  logic [y420rgb_pkg::SAMPLE_W-1:0]        cr_m;
  logic signed [y420rgb_pkg::SUM_W-1:0]    d_w;
  logic signed [y420rgb_pkg::SUM_W-1:0]    e_w;
  y420rgb_pkg::chroma_terms_t              terms_d;
  y420rgb_pkg::chroma_terms_t              terms_q;

  always_comb begin
    cb_m = show_blue_diff_i ? chroma_blue_i : '0;
    cr_m = show_red_diff_i ? chroma_red_i : '0;
    d_w  = signed'(y420rgb_pkg::SUM_W'(cb_m)) - y420rgb_pkg::CHROMA_OFS;
    e_w  = signed'(y420rgb_pkg::SUM_W'(cr_m)) - y420rgb_pkg::CHROMA_OFS;

    terms_d.r_term = e_w * y420rgb_pkg::COEF_R_CR + y420rgb_pkg::ROUND;
    terms_d.g_term = y420rgb_pkg::ROUND - d_w * y420rgb_pkg::COEF_G_CB
                     - e_w * y420rgb_pkg::COEF_G_CR;
    terms_d.b_term = d_w * y420rgb_pkg::COEF_B_CB + y420rgb_pkg::ROUND;

    // Exactly one plane shown selects the gray view of that plane.
    terms_d.gray_en   = $onehot({show_luma_i, show_blue_diff_i, show_red_diff_i});
    terms_d.gray_luma = show_luma_i;
    terms_d.gray_val  = show_blue_diff_i ? cb_m : cr_m;
  end

  always_ff @(posedge clk_i) begin
    terms_q <= terms_d;
  end

  assign terms_o = terms_q;

endmodule

`default_nettype wire

// ----- rtl/y420rgb_lane.sv -----
// One pixel lane: luma product, chroma addition, floor shift and clamp, or a gray view.
// Depends on y420rgb_pkg; takes the chroma terms from y420rgb_chroma.
`default_nettype none

module y420rgb_lane (
  input  wire logic                             clk_i,
  input  wire logic                             show_luma_i,
  input  wire logic [y420rgb_pkg::SAMPLE_W-1:0] luma_i,
  input  wire y420rgb_pkg::chroma_terms_t       terms_i,
  output y420rgb_pkg::pixel_t                   pixel_o
);

  logic [y420rgb_pkg::SAMPLE_W-1:0]     y_m;
  logic signed [y420rgb_pkg::SUM_W-1:0] c_w;
  logic signed [y420rgb_pkg::SUM_W-1:0] yprod_d;
  logic signed [y420rgb_pkg::SUM_W-1:0] yprod_q;
  logic [y420rgb_pkg::SAMPLE_W-1:0]     luma_q;
  logic signed [y420rgb_pkg::SUM_W-1:0] sum_r;
  logic signed [y420rgb_pkg::SUM_W-1:0] sum_g;
  logic signed [y420rgb_pkg::SUM_W-1:0] sum_b;
  y420rgb_pkg::pixel_t                  pixel_d;
  y420rgb_pkg::pixel_t                  pixel_q;

  // Negative sums give zero; otherwise drop eight fraction bits and saturate.
  function automatic logic [y420rgb_pkg::SAMPLE_W-1:0] clip_shift(
    input logic signed [y420rgb_pkg::SUM_W-1:0] sum
  );
    logic [y420rgb_pkg::SAMPLE_W-1:0] res;
    if (sum[y420rgb_pkg::SUM_W-1]) begin
      res = '0;
    end else if (|sum[y420rgb_pkg::SUM_W-2:2*y420rgb_pkg::SAMPLE_W]) begin
      res = '1;
    end else begin
      res = sum[2*y420rgb_pkg::SAMPLE_W-1:y420rgb_pkg::SAMPLE_W];
    end
    return res;
  endfunction

  always_comb begin
    y_m     = show_luma_i ? luma_i : '0;
    c_w     = signed'(y420rgb_pkg::SUM_W'(y_m)) - y420rgb_pkg::LUMA_OFS;
    yprod_d = c_w * y420rgb_pkg::COEF_Y;
  end

  always_ff @(posedge clk_i) begin
    yprod_q <= yprod_d;
    luma_q  <= y_m;
  end

  always_comb begin
    sum_r = yprod_q + terms_i.r_term;
    sum_g = yprod_q + terms_i.g_term;
    sum_b = yprod_q + terms_i.b_term;
    if (terms_i.gray_en) begin
      if (terms_i.gray_luma) begin
        pixel_d = '{r: luma_q, g: luma_q, b: luma_q};
      end else begin
        pixel_d = '{r: terms_i.gray_val, g: terms_i.gray_val, b: terms_i.gray_val};
      end
    end else begin
      pixel_d = '{r: clip_shift(sum_r), g: clip_shift(sum_g), b: clip_shift(sum_b)};
    end
  end

  always_ff @(posedge clk_i) begin
    pixel_q <= pixel_d;
  end

  assign pixel_o = pixel_q;

endmodule

`default_nettype wire

// ----- rtl/y420rgb_merge.sv -----
// Merge stage: packs the four lane pixels into 24-bit words and drives the strobe.
// Depends on y420rgb_pkg; fed by the four y420rgb_lane instances.
`default_nettype none

module y420rgb_merge (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            valid_i,
  input  wire y420rgb_pkg::pixel_t             pixels_i [y420rgb_pkg::LANES],
  output logic                                 valid_o,
  output logic [y420rgb_pkg::PIXEL_W-1:0]      words_o [y420rgb_pkg::LANES]
);

  logic                             valid_q;
  logic [y420rgb_pkg::PIXEL_W-1:0]  words_q [y420rgb_pkg::LANES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  // Only the strobed cycle carries meaning, so capture only then.
  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      for (int k = 0; k < y420rgb_pkg::LANES; k++) begin
        words_q[k] <= {pixels_i[k].r, pixels_i[k].g, pixels_i[k].b};
      end
    end
  end

  assign valid_o = valid_q;
  assign words_o = words_q;

endmodule

`default_nettype wire

// ----- rtl/yuv420_block_to_rgb_converter.sv -----
// Top level of the YUV 4:2:0 block to RGB converter (BT.601 integer form).
// Depends on y420rgb_pkg, y420rgb_chroma, y420rgb_lane and y420rgb_merge.
//
// The converter takes one 2x2 luma block with its shared Cb and Cr sample in
// every clock cycle and returns the four pixels as packed 24-bit RGB words
// (red 23:16, green 15:8, blue 7:0). busy is always low, so an item is taken
// on every cycle in which start is high. Each item produces exactly one
// result, shown for a single cycle with valid_o high. The receiver cannot
// stall the result, and none is needed: the fixed three-stage pipeline
// (chroma terms and luma products, per-pixel sums with clamping, output
// packing) advances every cycle. Throughput is one item per clock cycle.
// The show_luma, show_blue_diff and show_red_diff registers sit on the
// APB port at byte addresses 0, 4 and 8 and reset to one; they should be
// changed only while no item is in flight.
`default_nettype none

module yuv420_block_to_rgb_converter (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,

  // Item channel.
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic [y420rgb_pkg::SAMPLE_W-1:0]     luma_top_left_i,
  input  wire logic [y420rgb_pkg::SAMPLE_W-1:0]     luma_top_right_i,
  input  wire logic [y420rgb_pkg::SAMPLE_W-1:0]     luma_bottom_left_i,
  input  wire logic [y420rgb_pkg::SAMPLE_W-1:0]     luma_bottom_right_i,
  input  wire logic [y420rgb_pkg::SAMPLE_W-1:0]     chroma_blue_i,
  input  wire logic [y420rgb_pkg::SAMPLE_W-1:0]     chroma_red_i,

  // Result channel.
  output logic                                      valid_o,
  output logic [y420rgb_pkg::PIXEL_W-1:0]           rgb_top_left_o,
  output logic [y420rgb_pkg::PIXEL_W-1:0]           rgb_top_right_o,
  output logic [y420rgb_pkg::PIXEL_W-1:0]           rgb_bottom_left_o,
  output logic [y420rgb_pkg::PIXEL_W-1:0]           rgb_bottom_right_o,

  // Configuration port.
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [y420rgb_pkg::PADDR_W-1:0]      paddr,
  input  wire logic [y420rgb_pkg::PDATA_W-1:0]      pwdata,
  output logic [y420rgb_pkg::PDATA_W-1:0]           prdata,
  output logic                                      pready
);

  logic                                  show_luma_q;
  logic                                  show_blue_diff_q;
  logic                                  show_red_diff_q;
  logic                                  cfg_wr;
  logic [y420rgb_pkg::REG_IDX_W-1:0]     cfg_idx;

  logic                                  accept;
  logic                                  stage1_valid_q;
  logic                                  stage2_valid_q;

  logic [y420rgb_pkg::SAMPLE_W-1:0]      luma_w [y420rgb_pkg::LANES];
  y420rgb_pkg::chroma_terms_t            terms;
  y420rgb_pkg::pixel_t                   pixels [y420rgb_pkg::LANES];
  logic [y420rgb_pkg::PIXEL_W-1:0]       words [y420rgb_pkg::LANES];

  // The pipeline never stalls, so the converter is never busy.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // ---------------------------------------------------------------------------
  // Configuration registers. Every access completes in its access cycle, and
  // only bit 0 of the written data is kept. Writes above the last register
  // are dropped.
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[y420rgb_pkg::PADDR_W-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      show_luma_q      <= 1'b1;
      show_blue_diff_q <= 1'b1;
      show_red_diff_q  <= 1'b1;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        y420rgb_pkg::REG_SHOW_LUMA:      show_luma_q      <= pwdata[0];
        y420rgb_pkg::REG_SHOW_BLUE_DIFF: show_blue_diff_q <= pwdata[0];
        y420rgb_pkg::REG_SHOW_RED_DIFF:  show_red_diff_q  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      y420rgb_pkg::REG_SHOW_LUMA:
        prdata = y420rgb_pkg::PDATA_W'(show_luma_q);
      y420rgb_pkg::REG_SHOW_BLUE_DIFF:
        prdata = y420rgb_pkg::PDATA_W'(show_blue_diff_q);
      y420rgb_pkg::REG_SHOW_RED_DIFF:
        prdata = y420rgb_pkg::PDATA_W'(show_red_diff_q);
      default:
        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Valid tracking for the first two stages; the merge stage owns the last.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage1_valid_q <= 1'b0;
      stage2_valid_q <= 1'b0;
    end else begin
      stage1_valid_q <= accept;
      stage2_valid_q <= stage1_valid_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath: one shared chroma unit, four pixel lanes, one merge stage.
  // ---------------------------------------------------------------------------
  assign luma_w[0] = luma_top_left_i;
  assign luma_w[1] = luma_top_right_i;
  assign luma_w[2] = luma_bottom_left_i;
  assign luma_w[3] = luma_bottom_right_i;

  y420rgb_chroma u_chroma (
    .clk_i            (clk_i),
    .show_luma_i      (show_luma_q),
    .show_blue_diff_i (show_blue_diff_q),
    .show_red_diff_i  (show_red_diff_q),
    .chroma_blue_i    (chroma_blue_i),
    .chroma_red_i     (chroma_red_i),
    .terms_o          (terms)
  );

  for (genvar k = 0; k < y420rgb_pkg::LANES; k++) begin : g_lane
    y420rgb_lane u_lane (
      .clk_i       (clk_i),
      .show_luma_i (show_luma_q),
      .luma_i      (luma_w[k]),
      .terms_i     (terms),
      .pixel_o     (pixels[k])
    );
  end

  y420rgb_merge u_merge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (stage2_valid_q),
    .pixels_i (pixels),
    .valid_o  (valid_o),
    .words_o  (words)
  );

  assign rgb_top_left_o     = words[0];
  assign rgb_top_right_o    = words[1];
  assign rgb_bottom_left_o  = words[2];
  assign rgb_bottom_right_o = words[3];

  // stage1_valid_q exists only to feed stage2_valid_q; the lanes and chroma
  // stage run freely and the merge stage captures on the strobe.

endmodule

`default_nettype wire

// ----- rtl/y420rgb_checker.sv -----
// Port-level checker for the YUV 4:2:0 block to RGB converter, bound to the top.
// Depends on y420rgb_pkg and on the port list of yuv420_block_to_rgb_converter.
`default_nettype none

module y420rgb_checker (
  input wire logic                                 clk_i,
  input wire logic                                 rst_ni,
  input wire logic                                 start,
  input wire logic                                 busy,
  input wire logic [y420rgb_pkg::SAMPLE_W-1:0]     luma_top_left_i,
  input wire logic [y420rgb_pkg::SAMPLE_W-1:0]     luma_top_right_i,
  input wire logic [y420rgb_pkg::SAMPLE_W-1:0]     luma_bottom_left_i,
  input wire logic [y420rgb_pkg::SAMPLE_W-1:0]     luma_bottom_right_i,
  input wire logic                                 valid_o,
  input wire logic [y420rgb_pkg::PIXEL_W-1:0]      rgb_top_left_o,
  input wire logic [y420rgb_pkg::PIXEL_W-1:0]      rgb_top_right_o,
  input wire logic [y420rgb_pkg::PIXEL_W-1:0]      rgb_bottom_left_o,
  input wire logic [y420rgb_pkg::PIXEL_W-1:0]      rgb_bottom_right_o,
  input wire logic                                 psel,
  input wire logic                                 penable,
  input wire logic                                 pwrite,
  input wire logic [y420rgb_pkg::PADDR_W-1:0]      paddr,
  input wire logic [y420rgb_pkg::PDATA_W-1:0]      pwdata,
  input wire logic [y420rgb_pkg::PDATA_W-1:0]      prdata,
  input wire logic                                 pready
);

  logic accept;
  logic same_luma;
  logic luma_wr;
  logic luma_rd;

  assign accept    = start && !busy;
  assign same_luma = (luma_top_left_i == luma_top_right_i) &&
                     (luma_top_left_i == luma_bottom_left_i) &&
                     (luma_top_left_i == luma_bottom_right_i);
  assign luma_wr   = psel && penable && pwrite && pready &&
                     (paddr[y420rgb_pkg::PADDR_W-1:2] == y420rgb_pkg::REG_SHOW_LUMA);
  assign luma_rd   = psel && !pwrite &&
                     (paddr[y420rgb_pkg::PADDR_W-1:2] == y420rgb_pkg::REG_SHOW_LUMA);

  // Every accepted item yields its result, with valid_o high.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##3 valid_o)
    else $error("accepted item produced no result");

  // No result appears without an earlier accepted item.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(accept, 3))
    else $error("result without an accepted item");

  // Four equal luma samples must give four equal pixels.
  a_lanes_agree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && $past(same_luma, 3)) |->
      (rgb_top_left_o == rgb_top_right_o) &&
      (rgb_top_left_o == rgb_bottom_left_o) &&
      (rgb_top_left_o == rgb_bottom_right_o))
    else $error("lanes disagree on equal luma");

  // A read right after a write to show_luma returns the written bit.
  a_cfg_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(luma_wr) && luma_rd) |-> (prdata[0] == $past(pwdata[0])))
    else $error("show_luma readback mismatch");

endmodule

bind yuv420_block_to_rgb_converter y420rgb_checker u_y420rgb_checker (.*);

`default_nettype wire
